// ===== hw/rtl/mwcm_pkg.sv =====
// Shared types, constants and register codes of the memory word change monitor.
`default_nettype none

package mwcm_pkg;

   localparam int IDX_W      = 4;
   localparam int VAL_W      = 32;
   localparam int CNT_W      = 20;
   localparam int SEC_W      = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_SEL_W  = 3;

   localparam int DEFAULT_WORDS = 16;

   localparam logic [CNT_W-1:0] COUNT_CAP     = 20'd1000000;
   localparam logic [SEC_W-1:0] SETTLE_RESET  = 16'd3;
   localparam logic [SEC_W-1:0] ONE_SECOND    = 16'd1;
   localparam logic signed [VAL_W-1:0] VAL_ZERO    = 32'sd0;
   localparam logic signed [VAL_W-1:0] VAL_ONE     = 32'sd1;
   localparam logic signed [VAL_W-1:0] VAL_NEG_ONE = -32'sd1;

   localparam logic OP_CAPTURE = 1'b0;
   localparam logic OP_UPDATE  = 1'b1;

   localparam logic [REG_SEL_W-1:0] REG_BOOLEAN_ONLY   = 3'd0;
   localparam logic [REG_SEL_W-1:0] REG_SETTLE_SECONDS = 3'd1;
   localparam logic [REG_SEL_W-1:0] REG_VALUE_MIN      = 3'd2;
   localparam logic [REG_SEL_W-1:0] REG_VALUE_MAX      = 3'd3;
   localparam logic [REG_SEL_W-1:0] REG_COUNT_MIN      = 3'd4;
   localparam logic [REG_SEL_W-1:0] REG_COUNT_MAX      = 3'd5;
   localparam logic [REG_SEL_W-1:0] REG_RATE_MIN       = 3'd6;
   localparam logic [REG_SEL_W-1:0] REG_RATE_MAX       = 3'd7;

   typedef struct packed {
      logic                    boolean_only;
      logic [SEC_W-1:0]        settle_seconds;
      logic signed [VAL_W-1:0] value_min;
      logic signed [VAL_W-1:0] value_max;
      logic [CNT_W-1:0]        count_min;
      logic [CNT_W-1:0]        count_max;
      logic [CNT_W-1:0]        rate_min;
      logic [CNT_W-1:0]        rate_max;
   } mwcm_cfg_type;

   // word leaving the update stage toward the filters
   typedef struct packed {
      logic [IDX_W-1:0]        index;
      logic signed [VAL_W-1:0] value;
      logic                    changed;
      logic [CNT_W-1:0]        total;
      logic [SEC_W-1:0]        elapsed;
      logic                    update;
   } mwcm_item_type;

endpackage

`default_nettype wire

// ===== hw/rtl/memory_word_change_monitor.sv =====
// Top level of the memory word change monitor.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   op, word_index, sample, elapsed_seconds
//   rsp_      out        rsp_valid/rsp_stall   out_index, out_value, changed,
//                                              change_total, report
//   csr_      in/out     psel/penable/pready   paddr, pwdata, prdata
//
// One word per cycle sustained while rsp_stall stays low; a word reaches rsp_valid through
// five register stages (input, entry read, update/write-back, rate products, output).
// The entry memory is read ahead from the input stage with a bypass, so the same word may follow
// itself back to back. Every stage holds its own valid; bubbles are squeezed out under
// rsp_stall. Synchronous reset clears the valid bits and the configuration registers;
// the entry memory is not cleared and a word must be captured before it is updated.
`default_nettype none

module memory_word_change_monitor #(
   parameter int WORDS = mwcm_pkg::DEFAULT_WORDS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_op,
   input  wire logic [mwcm_pkg::IDX_W-1:0]        req_word_index,
   input  wire logic signed [mwcm_pkg::VAL_W-1:0] req_sample,
   input  wire logic [mwcm_pkg::SEC_W-1:0]        req_elapsed_seconds,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [mwcm_pkg::IDX_W-1:0]             rsp_out_index,
   output logic signed [mwcm_pkg::VAL_W-1:0]      rsp_out_value,
   output logic                                   rsp_changed,
   output logic [mwcm_pkg::CNT_W-1:0]             rsp_change_total,
   output logic                                   rsp_report,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [mwcm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [mwcm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [mwcm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);
   import mwcm_pkg::*;

   mwcm_cfg_type  cfg;
   mwcm_item_type item;
   logic          item_valid;
   logic          flt_ready;

   mwcm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mwcm_state #(
      .WORDS (WORDS)
   ) u_state (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_word_index      (req_word_index),
      .req_sample          (req_sample),
      .req_elapsed_seconds (req_elapsed_seconds),
      .cfg                 (cfg),
      .flt_ready           (flt_ready),
      .item_valid          (item_valid),
      .item                (item)
   );

   mwcm_filter u_filter (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .cfg              (cfg),
      .flt_ready        (flt_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_index    (rsp_out_index),
      .rsp_out_value    (rsp_out_value),
      .rsp_changed      (rsp_changed),
      .rsp_change_total (rsp_change_total),
      .rsp_report       (rsp_report)
   );

   // empty output register means the whole pipe can move
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty output register");

   a_clear_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_report_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report |-> 32'(rsp_out_index) < 32'(WORDS))
      else $error("report raised for a word outside the watched set");

   a_changed_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_changed |-> 32'(rsp_out_index) < 32'(WORDS))
      else $error("change flagged for a word outside the watched set");

endmodule

`default_nettype wire

// ===== hw/rtl/mwcm_csr.sv =====
// Configuration register file with APB-style access.
`default_nettype none

module mwcm_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [mwcm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [mwcm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [mwcm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready,
   output mwcm_pkg::mwcm_cfg_type               cfg
);
   import mwcm_pkg::*;

   mwcm_cfg_type cfg_ff;
   logic [REG_SEL_W-1:0] reg_sel;
   logic wr_en;

   assign reg_sel    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boolean_only   <= 1'b0;
         cfg_ff.settle_seconds <= SETTLE_RESET;
         cfg_ff.value_min      <= VAL_ZERO;
         cfg_ff.value_max      <= VAL_ZERO;
         cfg_ff.count_min      <= '0;
         cfg_ff.count_max      <= '0;
         cfg_ff.rate_min       <= '0;
         cfg_ff.rate_max       <= '0;
      end else if (wr_en) begin
         case (reg_sel)
            REG_BOOLEAN_ONLY:   cfg_ff.boolean_only   <= csr_pwdata[0];
            REG_SETTLE_SECONDS: cfg_ff.settle_seconds <= csr_pwdata[SEC_W-1:0];
            REG_VALUE_MIN:      cfg_ff.value_min      <= $signed(csr_pwdata[VAL_W-1:0]);
            REG_VALUE_MAX:      cfg_ff.value_max      <= $signed(csr_pwdata[VAL_W-1:0]);
            REG_COUNT_MIN:      cfg_ff.count_min      <= csr_pwdata[CNT_W-1:0];
            REG_COUNT_MAX:      cfg_ff.count_max      <= csr_pwdata[CNT_W-1:0];
            REG_RATE_MIN:       cfg_ff.rate_min       <= csr_pwdata[CNT_W-1:0];
            REG_RATE_MAX:       cfg_ff.rate_max       <= csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_BOOLEAN_ONLY:   csr_prdata = CSR_DATA_W'(cfg_ff.boolean_only);
         REG_SETTLE_SECONDS: csr_prdata = CSR_DATA_W'(cfg_ff.settle_seconds);
         REG_VALUE_MIN:      csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.value_min));
         REG_VALUE_MAX:      csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.value_max));
         REG_COUNT_MIN:      csr_prdata = CSR_DATA_W'(cfg_ff.count_min);
         REG_COUNT_MAX:      csr_prdata = CSR_DATA_W'(cfg_ff.count_max);
         REG_RATE_MIN:       csr_prdata = CSR_DATA_W'(cfg_ff.rate_min);
         REG_RATE_MAX:       csr_prdata = CSR_DATA_W'(cfg_ff.rate_max);
         default:            csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mwcm_state.sv =====
// Input, state read and update stages with the per-word mirror and count memory.
`default_nettype none

module mwcm_state #(
   parameter int WORDS = mwcm_pkg::DEFAULT_WORDS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_op,
   input  wire logic [mwcm_pkg::IDX_W-1:0]        req_word_index,
   input  wire logic signed [mwcm_pkg::VAL_W-1:0] req_sample,
   input  wire logic [mwcm_pkg::SEC_W-1:0]        req_elapsed_seconds,
   input  mwcm_pkg::mwcm_cfg_type                 cfg,
   input  wire logic                              flt_ready,
   output logic                                   item_valid,
   output mwcm_pkg::mwcm_item_type                item
);
   import mwcm_pkg::*;

   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int ENT_W = CNT_W + VAL_W;

   logic [ENT_W-1:0] entry_mem [WORDS];

   logic                    s1_valid_ff;
   logic                    s1_op_ff;
   logic [IDX_W-1:0]        s1_idx_ff;
   logic signed [VAL_W-1:0] s1_sample_ff;
   logic [SEC_W-1:0]        s1_elapsed_ff;

   logic                    s2_valid_ff;
   logic                    s2_op_ff;
   logic [IDX_W-1:0]        s2_idx_ff;
   logic signed [VAL_W-1:0] s2_sample_ff;
   logic [SEC_W-1:0]        s2_elapsed_ff;
   logic [ENT_W-1:0]        rd_data_ff;
   logic [ENT_W-1:0]        rd_data_in;

   logic                    s3_valid_ff;
   mwcm_item_type           s3_item_ff;
   mwcm_item_type           s3_item_in;

   logic ld1, ld2, ld3;
   logic [AW-1:0] rd_addr, wr_addr;
   logic wr_en;
   logic [ENT_W-1:0] wr_data;
   logic in_range, is_update, upd_ok, diff;
   logic [VAL_W-1:0] old_mirror;
   logic [CNT_W-1:0] old_count, cnt_inc, cnt_new;

   assign ld3        = !s3_valid_ff || flt_ready;
   assign ld2        = !s2_valid_ff || ld3;
   assign ld1        = !s1_valid_ff || ld2;
   assign req_stall  = !ld1;
   assign item_valid = s3_valid_ff;
   assign item       = s3_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (ld1) s1_valid_ff <= req_valid;
         if (ld2) s2_valid_ff <= s1_valid_ff;
         if (ld3) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_op_ff      <= req_op;
         s1_idx_ff     <= req_word_index;
         s1_sample_ff  <= req_sample;
         s1_elapsed_ff <= req_elapsed_seconds;
      end
      if (ld2) begin
         s2_op_ff      <= s1_op_ff;
         s2_idx_ff     <= s1_idx_ff;
         s2_sample_ff  <= s1_sample_ff;
         s2_elapsed_ff <= s1_elapsed_ff;
      end
      if (ld3) s3_item_ff <= s3_item_in;
   end

   // read-modify-write of the word's entry
   assign in_range   = 32'(s2_idx_ff) < 32'(WORDS);
   assign is_update  = (s2_op_ff == OP_UPDATE);
   assign upd_ok     = in_range && is_update;
   assign old_mirror = rd_data_ff[VAL_W-1:0];
   assign old_count  = rd_data_ff[ENT_W-1:VAL_W];
   assign diff       = (old_mirror != $unsigned(s2_sample_ff));
   assign cnt_inc    = (old_count < COUNT_CAP) ? old_count + CNT_W'(1) : old_count;
   assign cnt_new    = (s2_elapsed_ff < cfg.settle_seconds) ? COUNT_CAP : cnt_inc;

   assign wr_en   = s2_valid_ff && ld3 && in_range && (!is_update || diff);
   assign wr_addr = AW'(s2_idx_ff);
   assign wr_data = {(is_update ? cnt_new : CNT_W'(0)), $unsigned(s2_sample_ff)};
   assign rd_addr = AW'(s1_idx_ff);

   always_comb begin
      s3_item_in.index   = s2_idx_ff;
      s3_item_in.value   = s2_sample_ff;
      s3_item_in.changed = upd_ok && diff;
      s3_item_in.total   = !upd_ok ? CNT_W'(0) : (diff ? cnt_new : old_count);
      s3_item_in.elapsed = s2_elapsed_ff;
      s3_item_in.update  = upd_ok;
   end

   // a write on the same edge as the read is forwarded
   assign rd_data_in = (wr_en && (wr_addr == rd_addr)) ? wr_data : entry_mem[rd_addr];

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (ld2) rd_data_ff <= rd_data_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mwcm_filter.sv =====
// Report filter stages: rate bound products, compares and the output register.
`default_nettype none

module mwcm_filter (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       item_valid,
   input  mwcm_pkg::mwcm_item_type         item,
   input  mwcm_pkg::mwcm_cfg_type          cfg,
   output logic                            flt_ready,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [mwcm_pkg::IDX_W-1:0]      rsp_out_index,
   output logic signed [mwcm_pkg::VAL_W-1:0] rsp_out_value,
   output logic                            rsp_changed,
   output logic [mwcm_pkg::CNT_W-1:0]      rsp_change_total,
   output logic                            rsp_report
);
   import mwcm_pkg::*;

   localparam int PMIN_W = CNT_W + SEC_W;
   localparam int PMAX_W = CNT_W + 1 + SEC_W;

   logic              s4_valid_ff;
   mwcm_item_type     s4_item_ff;
   logic              s4_pre_ok_ff, s4_pre_ok_in;
   logic [PMIN_W-1:0] s4_prod_min_ff, s4_prod_min_in;
   logic [PMAX_W-1:0] s4_prod_max_ff, s4_prod_max_in;

   logic                    rsp_valid_ff;
   logic [IDX_W-1:0]        rsp_index_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic                    rsp_changed_ff;
   logic [CNT_W-1:0]        rsp_total_ff;
   logic                    rsp_report_ff, rsp_report_in;

   logic ld4, ld5;
   logic [SEC_W-1:0] secs;
   logic bool_ok, vmin_ok, vmax_ok, cmin_ok, cmax_ok, rmin_ok, rmax_ok;

   assign ld5       = !rsp_valid_ff || !rsp_stall;
   assign ld4       = !s4_valid_ff || ld5;
   assign flt_ready = ld4;

   // rate = count / secs is compared without a divide:
   //   rate < rate_min    <=> count <  rate_min * secs
   //   rate > rate_max    <=> count >= (rate_max + 1) * secs
   assign secs = (item.elapsed == '0) ? ONE_SECOND : item.elapsed;
   assign s4_prod_min_in = PMIN_W'(cfg.rate_min) * PMIN_W'(secs);
   assign s4_prod_max_in = (PMAX_W'(cfg.rate_max) + PMAX_W'(1)) * PMAX_W'(secs);

   assign bool_ok = !cfg.boolean_only || (item.value == VAL_ZERO) ||
                    (item.value == VAL_ONE) || (item.value == VAL_NEG_ONE);
   assign vmin_ok = (cfg.value_min == VAL_ZERO) || !(item.value < cfg.value_min);
   assign vmax_ok = (cfg.value_max == VAL_ZERO) || !(item.value > cfg.value_max);
   assign cmin_ok = (cfg.count_min == '0) || !(item.total < cfg.count_min);
   assign cmax_ok = (cfg.count_max == '0) || !(item.total > cfg.count_max);
   assign s4_pre_ok_in = item.update && bool_ok && vmin_ok && vmax_ok && cmin_ok && cmax_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld4) s4_valid_ff  <= item_valid;
         if (ld5) rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld4) begin
         s4_item_ff     <= item;
         s4_pre_ok_ff   <= s4_pre_ok_in;
         s4_prod_min_ff <= s4_prod_min_in;
         s4_prod_max_ff <= s4_prod_max_in;
      end
   end

   assign rmin_ok = (cfg.rate_min == '0) || (PMIN_W'(s4_item_ff.total) >= s4_prod_min_ff);
   assign rmax_ok = (cfg.rate_max == '0) || (PMAX_W'(s4_item_ff.total) < s4_prod_max_ff);
   assign rsp_report_in = s4_pre_ok_ff && rmin_ok && rmax_ok;

   always_ff @(posedge clock) begin
      if (ld5) begin
         rsp_index_ff   <= s4_item_ff.index;
         rsp_value_ff   <= s4_item_ff.value;
         rsp_changed_ff <= s4_item_ff.changed;
         rsp_total_ff   <= s4_item_ff.total;
         rsp_report_ff  <= rsp_report_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_index    = rsp_index_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_changed      = rsp_changed_ff;
   assign rsp_change_total = rsp_total_ff;
   assign rsp_report       = rsp_report_ff;

endmodule

`default_nettype wire
